### design/dra_pkg.sv
// Shared types and constants for the dirty region accumulator.
// Depends on nothing; used by dra_clip and dirty_region_accumulator.
`timescale 1ns / 1ps

package dra_pkg;

  // Action codes carried by an input beat.
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_FILL  = 2'd2
  } action_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 4;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_CANVAS_W = cfg_index_t'(0);
  localparam cfg_index_t REG_CANVAS_H = cfg_index_t'(1);
  localparam cfg_index_t REG_CAMERA_X = cfg_index_t'(2);
  localparam cfg_index_t REG_CAMERA_Y = cfg_index_t'(3);

  // Reset values of the canvas size registers.
  localparam int CANVAS_W_RESET = 640;
  localparam int CANVAS_H_RESET = 480;

  // Fixed field widths of a rectangle.
  localparam int RECT_POS_BITS  = 20;
  localparam int RECT_SIZE_BITS = 16;

  // Signed working width of the clipping arithmetic: holds the floored
  // origin plus the camera offset and the grown size with margin.
  localparam int WORK_BITS = RECT_POS_BITS + 3;

endpackage

### design/dra_clip.sv
// One axis of the rectangle front end: floor, camera shift and canvas clip.
// Depends on dra_pkg.
`timescale 1ns / 1ps

module dra_clip
  import dra_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic signed [RECT_POS_BITS-1:0]  raw_pos,
  input  logic        [RECT_SIZE_BITS-1:0] raw_size,
  input  logic        [COORD_BITS-1:0]     offset,
  input  logic        [COORD_BITS:0]       limit,
  output logic        [COORD_BITS-1:0]     pos,
  output logic        [COORD_BITS:0]       size,
  output logic                             keep
);

  localparam logic [RECT_POS_BITS-1:0] FRAC_MASK =
    RECT_POS_BITS'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [WORK_BITS-1:0] flo;
  logic                        grow;
  logic signed [WORK_BITS-1:0] sz;
  logic signed [WORK_BITS-1:0] pos0;
  logic signed [WORK_BITS-1:0] lim;
  logic signed [WORK_BITS-1:0] sum_left;
  logic                        neg;
  logic signed [WORK_BITS-1:0] pos_a;
  logic signed [WORK_BITS-1:0] size_a;
  logic signed [WORK_BITS-1:0] end_a;
  logic signed [WORK_BITS-1:0] size_c;
  logic                        drop_left;
  logic                        beyond;

  // Arithmetic shift floors the fixed-point origin; a fraction grows the size.
  assign flo  = WORK_BITS'(raw_pos >>> FRAC_BITS);
  assign grow = |(raw_pos & FRAC_MASK);
  assign sz   = $signed(WORK_BITS'(raw_size)) + $signed(WORK_BITS'(grow));
  assign pos0 = flo + $signed(WORK_BITS'(offset));
  assign lim  = $signed(WORK_BITS'(limit));

  // Cut off the part left of the canvas origin.
  assign neg       = pos0[WORK_BITS-1];
  assign sum_left  = sz + pos0;
  assign drop_left = neg && sum_left[WORK_BITS-1];
  assign pos_a     = neg ? '0 : pos0;
  assign size_a    = neg ? sum_left : sz;

  // Cut off the part beyond the far edge.
  assign beyond = pos_a >= lim;
  assign end_a  = pos_a + size_a;
  assign size_c = (end_a >= lim) ? (lim - pos_a) : size_a;

  assign keep = (raw_size != '0) && !drop_left && !beyond && (size_c != '0);
  assign pos  = pos_a[COORD_BITS-1:0];
  assign size = size_c[COORD_BITS:0];

endmodule

### design/dirty_region_accumulator.sv
// Dirty region accumulator: clips rectangles to the canvas and merges them
// into one dirty bounding box through the clip stage and result registers.
// Throughput one beat per cycle unless out_ready stalls the result channel,
// set by the clip stage and the merge stage each taking a beat per cycle.
// Reset (synchronous, rst_n low) empties the box, sets the canvas to 640 by
// 480 and the camera to the origin. Depends on dra_pkg and dra_clip.
`timescale 1ns / 1ps

module dirty_region_accumulator
  import dra_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [COORD_BITS:0]              cfg_data,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic signed [RECT_POS_BITS-1:0]  in_rect_x,
  input  logic signed [RECT_POS_BITS-1:0]  in_rect_y,
  input  logic [RECT_SIZE_BITS-1:0]        in_rect_w,
  input  logic [RECT_SIZE_BITS-1:0]        in_rect_h,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COORD_BITS-1:0]            out_box_x,
  output logic [COORD_BITS-1:0]            out_box_y,
  output logic [COORD_BITS:0]              out_box_w,
  output logic [COORD_BITS:0]              out_box_h,
  output logic signed [COORD_BITS:0]       out_view_x,
  output logic signed [COORD_BITS:0]       out_view_y,
  output logic                             out_is_empty
);

  localparam int SB = COORD_BITS + 1;
  localparam int EB = COORD_BITS + 2;

  // Configuration registers
  logic [COORD_BITS:0]   canvas_w_r, canvas_h_r;
  logic [COORD_BITS-1:0] camera_x_r, camera_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= SB'(CANVAS_W_RESET);
      canvas_h_r <= SB'(CANVAS_H_RESET);
      camera_x_r <= '0;
      camera_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CANVAS_W: canvas_w_r <= cfg_data;
        REG_CANVAS_H: canvas_h_r <= cfg_data;
        REG_CAMERA_X: camera_x_r <= cfg_data[COORD_BITS-1:0];
        REG_CAMERA_Y: camera_y_r <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Canvas sizes above the coordinate range saturate to it.
  logic [COORD_BITS:0] eff_w, eff_h;
  localparam logic [COORD_BITS:0] CANVAS_MAX = SB'(1) << COORD_BITS;

  assign eff_w = (canvas_w_r > CANVAS_MAX) ? CANVAS_MAX : canvas_w_r;
  assign eff_h = (canvas_h_r > CANVAS_MAX) ? CANVAS_MAX : canvas_h_r;

  // Handshake: each stage moves when the one after it has room.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_room;
  logic s1_move;
  logic in_take;

  assign out_room = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_room;
  assign in_ready = !s1_valid_r || out_room;
  assign in_take  = in_valid && in_ready;

  // Clip stage
  logic [COORD_BITS-1:0] cx, cy;
  logic [COORD_BITS:0]   cw, ch;
  logic                  keep_x, keep_y;

  dra_clip #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_clip_x (
    .raw_pos  (in_rect_x),
    .raw_size (in_rect_w),
    .offset   (camera_x_r),
    .limit    (eff_w),
    .pos      (cx),
    .size     (cw),
    .keep     (keep_x)
  );

  dra_clip #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_clip_y (
    .raw_pos  (in_rect_y),
    .raw_size (in_rect_h),
    .offset   (camera_y_r),
    .limit    (eff_h),
    .pos      (cy),
    .size     (ch),
    .keep     (keep_y)
  );

  logic [1:0]            s1_action_r;
  logic                  s1_keep_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [COORD_BITS:0]   s1_w_r, s1_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_keep_r   <= keep_x && keep_y;
      s1_x_r      <= cx;
      s1_y_r      <= cy;
      s1_w_r      <= cw;
      s1_h_r      <= ch;
    end
  end

  // Merge stage: box state and its next value
  logic [COORD_BITS-1:0] left_r, top_r, left_nxt, top_nxt;
  logic [COORD_BITS:0]   wid_r, hgt_r, wid_nxt, hgt_nxt;
  logic                  box_empty;
  logic [COORD_BITS-1:0] ml, mt;
  logic [EB-1:0]         r1, r2, b1, b2, mr, mb;

  assign box_empty = (wid_r == '0) || (hgt_r == '0);
  assign ml = (left_r < s1_x_r) ? left_r : s1_x_r;
  assign mt = (top_r < s1_y_r) ? top_r : s1_y_r;
  assign r1 = EB'(left_r) + EB'(wid_r);
  assign r2 = EB'(s1_x_r) + EB'(s1_w_r);
  assign b1 = EB'(top_r) + EB'(hgt_r);
  assign b2 = EB'(s1_y_r) + EB'(s1_h_r);
  assign mr = (r1 > r2) ? r1 : r2;
  assign mb = (b1 > b2) ? b1 : b2;

  always_comb begin
    left_nxt = left_r;
    top_nxt  = top_r;
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    unique case (s1_action_r)
      ACT_ADD: begin
        if (s1_keep_r) begin
          if (box_empty) begin
            left_nxt = s1_x_r;
            top_nxt  = s1_y_r;
            wid_nxt  = s1_w_r;
            hgt_nxt  = s1_h_r;
          end else begin
            left_nxt = ml;
            top_nxt  = mt;
            wid_nxt  = SB'(mr - EB'(ml));
            hgt_nxt  = SB'(mb - EB'(mt));
          end
        end
      end
      ACT_CLEAR: begin
        wid_nxt = '0;
        hgt_nxt = '0;
      end
      ACT_FILL: begin
        left_nxt = '0;
        top_nxt  = '0;
        wid_nxt  = eff_w;
        hgt_nxt  = eff_h;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      top_r  <= '0;
      wid_r  <= '0;
      hgt_r  <= '0;
    end else if (s1_move) begin
      left_r <= left_nxt;
      top_r  <= top_nxt;
      wid_r  <= wid_nxt;
      hgt_r  <= hgt_nxt;
    end
  end

  // Result register: the updated box, zeroed when empty.
  logic                  empty_nxt;
  logic [COORD_BITS:0]   view_x_nxt, view_y_nxt;
  logic [COORD_BITS-1:0] box_x_r, box_y_r;
  logic [COORD_BITS:0]   box_w_r, box_h_r;
  logic [COORD_BITS:0]   view_x_r, view_y_r;
  logic                  is_empty_r;

  assign empty_nxt  = (wid_nxt == '0) || (hgt_nxt == '0);
  assign view_x_nxt = SB'(left_nxt) - SB'(camera_x_r);
  assign view_y_nxt = SB'(top_nxt) - SB'(camera_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_room) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      box_x_r    <= empty_nxt ? '0 : left_nxt;
      box_y_r    <= empty_nxt ? '0 : top_nxt;
      box_w_r    <= empty_nxt ? '0 : wid_nxt;
      box_h_r    <= empty_nxt ? '0 : hgt_nxt;
      view_x_r   <= empty_nxt ? '0 : view_x_nxt;
      view_y_r   <= empty_nxt ? '0 : view_y_nxt;
      is_empty_r <= empty_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_box_x    = box_x_r;
  assign out_box_y    = box_y_r;
  assign out_box_w    = box_w_r;
  assign out_box_h    = box_h_r;
  assign out_view_x   = $signed(view_x_r);
  assign out_view_y   = $signed(view_y_r);
  assign out_is_empty = is_empty_r;

  // The empty flag agrees with the reported size.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (is_empty_r == ((box_w_r == '0) || (box_h_r == '0))))
    else $error("empty flag disagrees with box size");

  // An empty box reports a zero origin in both frames.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && is_empty_r) |->
      ((box_x_r == '0) && (box_y_r == '0) && (view_x_r == '0) && (view_y_r == '0)))
    else $error("empty box reports a nonzero origin");

  // The state only changes when a beat moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> ($stable(wid_r) && $stable(hgt_r) && $stable(left_r) && $stable(top_r)))
    else $error("box state changed without a beat");

endmodule
